[src/fplm_pkg.sv]
// ----------------------------------------------------------------------------
// fplm_pkg
// Shared constants, codes and controller/datapath types of the flash
// parameter log manager.
// ----------------------------------------------------------------------------
package fplm_pkg;

  // sector geometry
  localparam int unsigned SECTOR_WORDS = 256;
  localparam int unsigned WORD_BITS    = 32;
  localparam int unsigned ADDR_W       = $clog2(SECTOR_WORDS);
  localparam int unsigned IDX_W        = ADDR_W + 1;
  localparam int unsigned SIZE_W       = 8;
  localparam int unsigned SPAN_W       = WORD_BITS - 1;

  localparam logic [WORD_BITS-1:0] ERASED_WORD = '1;

  // item command codes
  typedef enum logic {
    CMD_BEGIN = 1'b0,
    CMD_DATA  = 1'b1
  } cmd_e;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ZERO,
    ST_PLACE,
    ST_CHECK,
    ST_FINISH
  } state_e;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_DATA,
    OP_BEGIN,
    OP_SWEEP,
    OP_FREE_AT,
    OP_FREE_END,
    OP_ERASE,
    OP_ZERO_SETUP,
    OP_ZERO,
    OP_CHECK_SETUP,
    OP_FINISH
  } dp_op_e;

  // datapath status seen by the controller
  typedef struct packed {
    logic pend;       // read data of the last issued sweep address is present
    logic word_zero;  // that word is all zeros
    logic word_ones;  // that word is erased
    logic corrupt;    // live block found there runs past the sector end
    logic sweep_end;  // sweep pointer reached its limit
    logic fit;        // new block fits from the current placement
    logic slot_free;  // output register can take a result this cycle
  } dp_status_t;

endpackage

[src/flash_parameter_log_manager.sv]
// ----------------------------------------------------------------------------
// flash_parameter_log_manager
// Emulated one-sector flash log holding a single live parameter block.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries items: cmd_i = 0 begins
//   a block of size_words_i data words, cmd_i = 1 programs data_word_i.
//   Output channel (out_valid_o / out_ready_i) returns one result per item.
//   A data item is finished in the accepting cycle; its result is shown on
//   the next cycle. A begin item scans the sector one word per cycle
//   through the RAM read port, zeroes the old block one word per cycle,
//   takes a placement step, checks the new block's n + 1 words, then
//   programs the size word. One item is processed at a time; in_ready_o
//   is high only when the controller is idle and the output register is
//   empty or being read. A stalled receiver holds the result in the output
//   register and blocks the next item. Reset marks every sector word erased
//   at once (per-word flags), so items are accepted as soon as reset is
//   released; a sector erase clears the same flags at once.
// ----------------------------------------------------------------------------
module flash_parameter_log_manager import fplm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 cmd_i,
  input  logic [SIZE_W-1:0]    size_words_i,
  input  logic [WORD_BITS-1:0] data_word_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [ADDR_W-1:0]    block_start_o,
  output logic                 sector_erased_o,
  output logic                 old_zeroed_o,
  output logic                 block_done_o,
  output logic                 error_o
);

  dp_op_e     op;
  dp_status_t status;

  // controller
  fplm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .status_i   (status),
    .op_o       (op)
  );

  // datapath
  fplm_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .op_i            (op),
    .status_o        (status),
    .size_words_i    (size_words_i),
    .data_word_i     (data_word_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .block_start_o   (block_start_o),
    .sector_erased_o (sector_erased_o),
    .old_zeroed_o    (old_zeroed_o),
    .block_done_o    (block_done_o),
    .error_o         (error_o)
  );

endmodule

[src/fplm_ram.sv]
// ----------------------------------------------------------------------------
// fplm_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module fplm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/fplm_ctrl.sv]
// ----------------------------------------------------------------------------
// fplm_ctrl
// Controller: walks a begin item through scan, retire, placement check and
// size word programming; data items complete in the accepting cycle.
// ----------------------------------------------------------------------------
module fplm_ctrl import fplm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       cmd_i,
  input  dp_status_t status_i,
  output dp_op_e     op_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE) && status_i.slot_free;

  // next state and datapath operation
  always_comb begin
    state_d = state_q;
    op_o    = OP_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          if (cmd_e'(cmd_i) == CMD_DATA) begin
            op_o = OP_DATA;
          end else begin
            op_o    = OP_BEGIN;
            state_d = ST_SCAN;
          end
        end
      end
      // skip zeroed words, stop at the first erased or live word
      ST_SCAN: begin
        priority if (status_i.pend && !status_i.word_zero) begin
          priority if (status_i.word_ones) begin
            op_o    = OP_FREE_AT;
            state_d = ST_PLACE;
          end else if (status_i.corrupt) begin
            op_o    = OP_ERASE;
            state_d = ST_PLACE;
          end else begin
            op_o    = OP_ZERO_SETUP;
            state_d = ST_ZERO;
          end
        end else if (!status_i.pend && status_i.sweep_end) begin
          op_o    = OP_FREE_END;
          state_d = ST_PLACE;
        end else begin
          op_o = OP_SWEEP;
        end
      end
      // retire the live block one word per cycle
      ST_ZERO: begin
        if (!status_i.sweep_end) begin
          op_o = OP_ZERO;
        end else begin
          state_d = ST_PLACE;
        end
      end
      ST_PLACE: begin
        if (status_i.fit) begin
          op_o    = OP_CHECK_SETUP;
          state_d = ST_CHECK;
        end else begin
          op_o    = OP_ERASE;
          state_d = ST_FINISH;
        end
      end
      // every word of the new block must still be erased
      ST_CHECK: begin
        priority if (status_i.pend && !status_i.word_ones) begin
          op_o    = OP_ERASE;
          state_d = ST_FINISH;
        end else if (!status_i.pend && status_i.sweep_end) begin
          state_d = ST_FINISH;
        end else begin
          op_o = OP_SWEEP;
        end
      end
      ST_FINISH: begin
        op_o    = OP_FINISH;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[src/fplm_dp.sv]
// ----------------------------------------------------------------------------
// fplm_dp
// Datapath: sector RAM with per-word erased flags, sweep pointer, block
// bookkeeping and the output register.
// ----------------------------------------------------------------------------
module fplm_dp import fplm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_op_e               op_i,
  output dp_status_t           status_o,
  input  logic [SIZE_W-1:0]    size_words_i,
  input  logic [WORD_BITS-1:0] data_word_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [ADDR_W-1:0]    block_start_o,
  output logic                 sector_erased_o,
  output logic                 old_zeroed_o,
  output logic                 block_done_o,
  output logic                 error_o
);

  // sweep and placement
  logic [IDX_W-1:0]     a_q;
  logic [IDX_W-1:0]     lim_q;
  logic [IDX_W-1:0]     rd_addr_q;
  logic                 pend_q;
  logic [IDX_W-1:0]     cur_q;
  logic [SIZE_W-1:0]    n_q;
  logic                 erased_q;
  logic                 zeroed_q;
  // open block
  logic [IDX_W-1:0]     write_index_q;
  logic [SIZE_W-1:0]    words_left_q;
  // output register
  logic                 out_valid_q;
  logic [ADDR_W-1:0]    block_start_q;
  logic                 sector_erased_q;
  logic                 old_zeroed_q;
  logic                 block_done_q;
  logic                 error_q;
  // word written since the last erase
  logic [SECTOR_WORDS-1:0] vld_q;
  logic                    vld_rd_q;

  logic                 we;
  logic [ADDR_W-1:0]    waddr;
  logic [WORD_BITS-1:0] wdata;
  logic [WORD_BITS-1:0] rdata;
  logic [WORD_BITS-1:0] word;
  logic [SPAN_W-1:0]    span;
  logic [WORD_BITS-1:0] zero_end;
  logic [IDX_W:0]       place_end;
  logic                 data_write;

  fplm_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (SECTOR_WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (a_q[ADDR_W-1:0]),
    .rdata_o (rdata)
  );

  // word at rd_addr_q, erased unless written since the last erase
  assign word      = vld_rd_q ? rdata : ERASED_WORD;
  assign span      = SPAN_W'(({1'b0, word} + (WORD_BITS+1)'(7)) >> 2);
  assign zero_end  = WORD_BITS'(rd_addr_q) + WORD_BITS'(span);
  assign place_end = (IDX_W+1)'(cur_q) + (IDX_W+1)'(n_q) + (IDX_W+1)'(1);

  assign data_write = (words_left_q != '0) && (write_index_q < IDX_W'(SECTOR_WORDS));

  always_comb begin
    status_o.pend      = pend_q;
    status_o.word_zero = (word == '0);
    status_o.word_ones = (word == ERASED_WORD);
    status_o.corrupt   = (zero_end > WORD_BITS'(SECTOR_WORDS));
    status_o.sweep_end = (a_q == lim_q);
    status_o.fit       = (place_end <= (IDX_W+1)'(SECTOR_WORDS));
    status_o.slot_free = !out_valid_q || out_ready_i;
  end

  // ram write port
  always_comb begin
    we    = 1'b0;
    waddr = a_q[ADDR_W-1:0];
    wdata = '0;
    unique case (op_i)
      OP_DATA: begin
        we    = data_write;
        waddr = write_index_q[ADDR_W-1:0];
        wdata = data_word_i;
      end
      OP_ZERO: begin
        we = 1'b1;
      end
      OP_FINISH: begin
        we    = 1'b1;
        waddr = cur_q[ADDR_W-1:0];
        wdata = WORD_BITS'({n_q, 2'b00});
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // written flags, erase clears them all at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (op_i == OP_ERASE) begin
      vld_q <= '0;
    end else if (we) begin
      vld_q[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    vld_rd_q <= vld_q[a_q[ADDR_W-1:0]];
  end

  // read data of an issued sweep address arrives in the following cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= (op_i == OP_SWEEP) && (a_q != lim_q);
    end
  end

  // sweep, placement and block bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q           <= '0;
      lim_q         <= '0;
      rd_addr_q     <= '0;
      cur_q         <= '0;
      n_q           <= '0;
      erased_q      <= 1'b0;
      zeroed_q      <= 1'b0;
      write_index_q <= '0;
      words_left_q  <= '0;
    end else begin
      unique case (op_i)
        OP_DATA: begin
          if (words_left_q != '0) begin
            write_index_q <= write_index_q + IDX_W'(1);
            words_left_q  <= words_left_q - SIZE_W'(1);
          end
        end
        OP_BEGIN: begin
          n_q      <= size_words_i;
          erased_q <= 1'b0;
          zeroed_q <= 1'b0;
          a_q      <= '0;
          lim_q    <= IDX_W'(SECTOR_WORDS);
        end
        OP_SWEEP: begin
          if (a_q != lim_q) begin
            a_q       <= a_q + IDX_W'(1);
            rd_addr_q <= a_q;
          end
        end
        OP_FREE_AT: begin
          cur_q <= rd_addr_q;
        end
        OP_FREE_END: begin
          cur_q <= a_q;
        end
        OP_ERASE: begin
          erased_q <= 1'b1;
          cur_q    <= '0;
        end
        OP_ZERO_SETUP: begin
          zeroed_q <= 1'b1;
          a_q      <= rd_addr_q;
          lim_q    <= zero_end[IDX_W-1:0];
          cur_q    <= zero_end[IDX_W-1:0];
        end
        OP_ZERO: begin
          a_q <= a_q + IDX_W'(1);
        end
        OP_CHECK_SETUP: begin
          a_q   <= cur_q;
          lim_q <= place_end[IDX_W-1:0];
        end
        OP_FINISH: begin
          write_index_q <= cur_q + IDX_W'(1);
          words_left_q  <= n_q;
        end
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if (op_i == OP_DATA || op_i == OP_FINISH) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i == OP_DATA) begin
      block_start_q   <= '0;
      sector_erased_q <= 1'b0;
      old_zeroed_q    <= 1'b0;
      block_done_q    <= (words_left_q == SIZE_W'(1));
      error_q         <= (words_left_q == '0);
    end else if (op_i == OP_FINISH) begin
      block_start_q   <= cur_q[ADDR_W-1:0];
      sector_erased_q <= erased_q;
      old_zeroed_q    <= zeroed_q;
      block_done_q    <= (n_q == '0);
      error_q         <= 1'b0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign block_start_o   = block_start_q;
  assign sector_erased_o = sector_erased_q;
  assign old_zeroed_o    = old_zeroed_q;
  assign block_done_o    = block_done_q;
  assign error_o         = error_q;

endmodule

[tb/sv/tb_flash_parameter_log_manager.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_flash_parameter_log_manager
// Self-checking bench for the flash parameter log manager. Items go in through
// the valid/ready input channel. A behavioral copy of the emulated sector
// predicts the result of each accepted item. A monitor compares every returned
// result, field by field, with the oldest prediction. Directed cases cover
// stray data, empty blocks, retire, abandon and full-sector corners. Random
// block sequences follow under three sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module tb_flash_parameter_log_manager;
  import fplm_pkg::*;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic              erased;
    logic              zeroed;
    logic              done;
    logic              err;
  } log_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic                 cmd_i = CMD_BEGIN;
  logic [SIZE_W-1:0]    size_words_i = '0;
  logic [WORD_BITS-1:0] data_word_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [ADDR_W-1:0]    block_start_o;
  logic                 sector_erased_o;
  logic                 old_zeroed_o;
  logic                 block_done_o;
  logic                 error_o;

  // model of the sector and the open block
  logic [WORD_BITS-1:0] flash_words [SECTOR_WORDS];
  int unsigned          next_data_idx;
  int unsigned          data_words_left;

  log_result_t          expected_results [$];
  int unsigned          fail_count = 0;
  int unsigned          items_sent = 0;
  int unsigned          send_idle_pct = 0;
  int unsigned          recv_idle_pct = 0;
  int unsigned          stall_request = 0;

  flash_parameter_log_manager DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .size_words_i   (size_words_i),
    .data_word_i    (data_word_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .block_start_o  (block_start_o),
    .sector_erased_o(sector_erased_o),
    .old_zeroed_o   (old_zeroed_o),
    .block_done_o   (block_done_o),
    .error_o        (error_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void erase_flash();
    foreach (flash_words[i]) flash_words[i] = ERASED_WORD;
  endfunction

  // expected result of one item, updates the sector model
  function automatic log_result_t predict_log(cmd_e cmd, logic [SIZE_W-1:0] n,
                                              logic [WORD_BITS-1:0] word);
    log_result_t res;
    int unsigned pos;
    int unsigned cur;
    int unsigned span;
    int unsigned k;
    logic        fit;
    res = '0;
    if (cmd == CMD_BEGIN) begin
      // skip retired words, then look for a live size word
      pos = 0;
      while (pos < SECTOR_WORDS && flash_words[pos] == '0) pos++;
      cur = pos;
      if (pos < SECTOR_WORDS && flash_words[pos] != ERASED_WORD) begin
        span = 32'((longint'(flash_words[pos]) + 7) / 4);
        if (pos + span > SECTOR_WORDS) begin
          erase_flash();
          res.erased = 1'b1;
          cur = 0;
        end else begin
          for (k = 0; k < span; k++) flash_words[pos + k] = '0;
          res.zeroed = 1'b1;
          cur = pos + span;
        end
      end
      // size word plus data must fit in erased space
      fit = (cur + 1 + n <= SECTOR_WORDS);
      if (fit) begin
        for (k = 0; k <= n; k++) begin
          if (flash_words[cur + k] != ERASED_WORD) fit = 1'b0;
        end
      end
      if (!fit) begin
        erase_flash();
        res.erased = 1'b1;
        cur = 0;
      end
      flash_words[cur] &= WORD_BITS'({n, 2'b00});
      next_data_idx = cur + 1;
      data_words_left = n;
      res.start = ADDR_W'(cur);
      res.done = (n == 0);
    end else if (data_words_left == 0) begin
      res.err = 1'b1;
    end else begin
      if (next_data_idx < SECTOR_WORDS) flash_words[next_data_idx] &= word;
      next_data_idx++;
      data_words_left--;
      res.done = (data_words_left == 0);
    end
    return res;
  endfunction

  function automatic logic [WORD_BITS-1:0] data_pattern();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // offer one item from a falling edge, return at the falling edge after accept
  task automatic send_item(cmd_e cmd, int unsigned n, logic [WORD_BITS-1:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cmd_i        <= cmd;
    size_words_i <= SIZE_W'(n);
    data_word_i  <= word;
    do @(posedge clk_i); while (!in_ready_o);
    expected_results.push_back(predict_log(cmd, SIZE_W'(n), word));
    items_sent++;
    @(negedge clk_i);
  endtask

  // receiver: random idling plus long hold-offs on request
  initial begin : result_receiver
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (stall_request != 0) begin
        stall_left = stall_request;
        stall_request = 0;
      end
      if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin : result_monitor
    log_result_t want;
    log_result_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{block_start_o, sector_erased_o, old_zeroed_o, block_done_o, error_o};
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        compare_field("block_start", want.start, got.start);
        compare_field("sector_erased", want.erased, got.erased);
        compare_field("old_zeroed", want.zeroed, got.zeroed);
        compare_field("block_done", want.done, got.done);
        compare_field("error", want.err, got.err);
      end
    end
  end

  // data with no open block
  task automatic test_data_without_block();
    send_item(CMD_DATA, $urandom_range(255), '1);
    send_item(CMD_DATA, $urandom_range(255), '0);
  endtask

  // zero-word block closes at once
  task automatic test_empty_block();
    send_item(CMD_BEGIN, 0, $urandom);
    send_item(CMD_DATA, $urandom_range(255), $urandom);
  endtask

  // short block with extreme data words
  task automatic test_short_block();
    send_item(CMD_BEGIN, 3, $urandom);
    send_item(CMD_DATA, $urandom_range(255), '0);
    send_item(CMD_DATA, $urandom_range(255), '1);
    send_item(CMD_DATA, $urandom_range(255), $urandom);
  endtask

  // next begin retires the previous block
  task automatic test_retire_block();
    send_item(CMD_BEGIN, 2, $urandom);
    send_item(CMD_DATA, $urandom_range(255), $urandom);
    send_item(CMD_DATA, $urandom_range(255), $urandom);
  endtask

  // begin while a block is still open
  task automatic test_abandoned_block();
    send_item(CMD_BEGIN, 4, $urandom);
    send_item(CMD_DATA, $urandom_range(255), $urandom);
    send_item(CMD_BEGIN, 1, $urandom);
    send_item(CMD_DATA, $urandom_range(255), $urandom);
  endtask

  // full-sector block, retire to the sector end, all-zero sector scan
  task automatic test_sector_corners();
    send_item(CMD_BEGIN, 255, $urandom);
    send_item(CMD_DATA, $urandom_range(255), '0);
    send_item(CMD_BEGIN, 254, $urandom);
    send_item(CMD_BEGIN, 0, $urandom);
    send_item(CMD_BEGIN, 0, $urandom);
  endtask

  // receiver holds off while items keep coming
  task automatic test_output_backpressure();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    stall_request = 400;
    @(negedge clk_i);
    send_item(CMD_BEGIN, 6, $urandom);
    repeat (6) send_item(CMD_DATA, $urandom_range(255), data_pattern());
  endtask

  // mostly well-formed block sequences, some abandoned, some stray items
  task automatic test_random_traffic(int unsigned count);
    int unsigned target;
    int unsigned size;
    int unsigned k;
    target = items_sent + count;
    while (items_sent < target) begin
      if ($urandom_range(99) < 85) begin
        size = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(12);
        send_item(CMD_BEGIN, size, $urandom);
        k = size;
        if ((size > 12) ? ($urandom_range(1) == 0) : ($urandom_range(7) == 0))
          k = $urandom_range((size > 12) ? 12 : size);
        repeat (k) send_item(CMD_DATA, $urandom_range(255), data_pattern());
        if ($urandom_range(9) == 0)
          send_item(CMD_DATA, $urandom_range(255), data_pattern());
      end else begin
        send_item(cmd_e'($urandom_range(1)), $urandom_range(255), data_pattern());
      end
    end
  endtask

  // test sequence
  initial begin
    erase_flash();
    next_data_idx = 0;
    data_words_left = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 22;
    recv_idle_pct = 80;
    test_data_without_block();
    test_empty_block();
    test_short_block();
    test_retire_block();
    test_abandoned_block();
    test_sector_corners();
    test_output_backpressure();
    test_random_traffic(300);

    send_idle_pct = 80;
    recv_idle_pct = 22;
    test_random_traffic(300);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(300);

    // drain
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

endmodule
